>>> rtl/core/mrt_pkg.sv
// Package with the constants, codes and record types of the mapped range table.
`timescale 1ns / 1ps
`default_nettype none

package mrt_pkg;

  localparam int ENTRIES     = 16;
  localparam int ADDR_BITS   = 48;
  localparam int LEN_BITS    = 32;
  localparam int SIZE_BITS   = 48;
  localparam int OFFSET_BITS = 48;
  localparam int MIP_BITS    = 4;
  localparam int ALLOC_BITS  = 16;

  localparam int IDX_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_BITS = $clog2(ENTRIES + 1);
  // A range end is kept exactly, with one carry bit above the wider operand.
  localparam int END_BITS = ((ADDR_BITS > LEN_BITS) ? ADDR_BITS : LEN_BITS) + 1;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_FIND_EXACT,
    OP_FIND_CONTAIN,
    OP_REMOVE
  } opcode_t;

  typedef enum logic [1:0] {
    STATUS_OK,
    STATUS_OVERLAP,
    STATUS_NOT_FOUND,
    STATUS_FULL
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ADD,
    ST_MOVE_RD,
    ST_MOVE_WR
  } state_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0]   start;
    logic [END_BITS-1:0]    end_addr;
    logic [LEN_BITS-1:0]    len;
    logic                   ro;
    logic [SIZE_BITS-1:0]   size;
    logic [OFFSET_BITS-1:0] offset;
    logic [MIP_BITS-1:0]    mip;
    logic [ALLOC_BITS-1:0]  alloc;
  } entry_t;

  typedef struct packed {
    opcode_t               op;
    logic [ADDR_BITS-1:0]  addr;
    logic [END_BITS-1:0]   end_addr;
  } query_t;

endpackage

`default_nettype wire

>>> rtl/core/mapped_range_table_core.sv
// Top level of the mapped range table: request sequencer, table and result registers.
//
//  channel   | handshake          | fields
//  ----------+--------------------+---------------------------------------------
//  request   | start, busy        | opcode address length read_only size_packed
//            |                    | offset_packed mip_level alloc_handle
//  result    | done (one cycle)   | status entry_count found_address found_length
//            |                    | found_read_only found_size found_offset
//            |                    | found_mip found_alloc
//
// A request is taken when start is high and busy is low. The table is scanned
// one entry per cycle through its single registered read port until a match or
// the last entry; a remove that hits then moves the last entry into the freed
// slot, and a read-only add skips the scan. Busy stays high until done.
// Synchronous reset empties the table by clearing the entry count only.
// The result is shown for one cycle and cannot be held off by the receiver.
`timescale 1ns / 1ps
`default_nettype none

module mapped_range_table_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      opcode,
  input  logic [mrt_pkg::ADDR_BITS-1:0]   address,
  input  logic [mrt_pkg::LEN_BITS-1:0]    length,
  input  logic                            read_only,
  input  logic [mrt_pkg::SIZE_BITS-1:0]   size_packed,
  input  logic [mrt_pkg::OFFSET_BITS-1:0] offset_packed,
  input  logic [mrt_pkg::MIP_BITS-1:0]    mip_level,
  input  logic [mrt_pkg::ALLOC_BITS-1:0]  alloc_handle,
  output logic                            done,
  output logic [1:0]                      status,
  output logic [mrt_pkg::CNT_BITS-1:0]    entry_count,
  output logic [mrt_pkg::ADDR_BITS-1:0]   found_address,
  output logic [mrt_pkg::LEN_BITS-1:0]    found_length,
  output logic                            found_read_only,
  output logic [mrt_pkg::SIZE_BITS-1:0]   found_size,
  output logic [mrt_pkg::OFFSET_BITS-1:0] found_offset,
  output logic [mrt_pkg::MIP_BITS-1:0]    found_mip,
  output logic [mrt_pkg::ALLOC_BITS-1:0]  found_alloc
);
  import mrt_pkg::*;

  state_t              state, state_next;
  logic [CNT_BITS-1:0] count, count_next;
  logic [CNT_BITS-1:0] issue_idx, issue_idx_next;
  logic                chk_vld, chk_vld_next;
  logic [IDX_BITS-1:0] chk_idx, chk_idx_next;
  logic                overlap, overlap_next;
  logic                done_next;
  status_t             res_status, res_status_next;
  entry_t              res_entry, res_entry_next;

  entry_t              req;
  query_t              query;
  logic                accept;
  logic                issue;
  logic                match;
  logic [CNT_BITS-1:0] cnt_m1;

  logic                we;
  logic [IDX_BITS-1:0] wr_addr;
  entry_t              wr_data;
  logic [IDX_BITS-1:0] rd_addr;
  entry_t              rd_data;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign issue  = (issue_idx < count);
  assign cnt_m1 = count - CNT_BITS'(1);

  // The request is held as a ready-made entry; its exact end is worked out on transfer.
  always_ff @(posedge clk) begin
    if (accept) begin
      query.op       <= opcode_t'(opcode);
      query.addr     <= address;
      query.end_addr <= END_BITS'(address) + END_BITS'(length);
      req.start      <= address;
      req.end_addr   <= END_BITS'(address) + END_BITS'(length);
      req.len        <= length;
      req.ro         <= read_only;
      req.size       <= size_packed;
      req.offset     <= offset_packed;
      req.mip        <= mip_level;
      req.alloc      <= alloc_handle;
    end
  end

  mrt_table u_table (
    .clk     (clk),
    .we      (we),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  mrt_match u_match (
    .query (query),
    .entry (rd_data),
    .match (match)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      issue_idx <= '0;
      chk_vld   <= 1'b0;
      overlap   <= 1'b0;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      issue_idx <= issue_idx_next;
      chk_vld   <= chk_vld_next;
      overlap   <= overlap_next;
      done      <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    chk_idx    <= chk_idx_next;
    res_status <= res_status_next;
    res_entry  <= res_entry_next;
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    issue_idx_next  = issue_idx;
    chk_vld_next    = chk_vld;
    chk_idx_next    = chk_idx;
    overlap_next    = overlap;
    done_next       = 1'b0;
    res_status_next = res_status;
    res_entry_next  = res_entry;
    we              = 1'b0;
    wr_addr         = count[IDX_BITS-1:0];
    wr_data         = req;
    rd_addr         = issue_idx[IDX_BITS-1:0];

    case (state)
      ST_IDLE: begin
        if (accept) begin
          issue_idx_next = '0;
          chk_vld_next   = 1'b0;
          overlap_next   = 1'b0;
          if ((opcode_t'(opcode) == OP_ADD) && read_only) begin
            state_next = ST_ADD;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // Reads are issued one ahead of the compare, which sees last cycle's entry.
        if (chk_vld && match) begin
          case (query.op)
            OP_ADD: begin
              overlap_next = 1'b1;
              state_next   = ST_ADD;
            end
            OP_REMOVE: begin
              state_next = ST_MOVE_RD;
            end
            default: begin
              done_next       = 1'b1;
              res_status_next = STATUS_OK;
              res_entry_next  = rd_data;
              state_next      = ST_IDLE;
            end
          endcase
        end else if (!issue && !chk_vld) begin
          if (query.op == OP_ADD) begin
            state_next = ST_ADD;
          end else begin
            done_next       = 1'b1;
            res_status_next = STATUS_NOT_FOUND;
            res_entry_next  = '0;
            state_next      = ST_IDLE;
          end
        end else begin
          chk_vld_next = issue;
          chk_idx_next = issue_idx[IDX_BITS-1:0];
          if (issue) begin
            issue_idx_next = issue_idx + CNT_BITS'(1);
          end
        end
      end

      ST_ADD: begin
        done_next      = 1'b1;
        res_entry_next = '0;
        state_next     = ST_IDLE;
        if (overlap) begin
          res_status_next = STATUS_OVERLAP;
        end else if (count == CNT_BITS'(ENTRIES)) begin
          res_status_next = STATUS_FULL;
        end else begin
          we              = 1'b1;
          count_next      = count + CNT_BITS'(1);
          res_status_next = STATUS_OK;
        end
      end

      ST_MOVE_RD: begin
        rd_addr    = cnt_m1[IDX_BITS-1:0];
        state_next = ST_MOVE_WR;
      end

      ST_MOVE_WR: begin
        // The last entry fills the freed slot; this is harmless when they coincide.
        we              = 1'b1;
        wr_addr         = chk_idx;
        wr_data         = rd_data;
        count_next      = cnt_m1;
        done_next       = 1'b1;
        res_status_next = STATUS_OK;
        res_entry_next  = '0;
        state_next      = ST_IDLE;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign status          = res_status;
  assign entry_count     = count;
  assign found_address   = res_entry.start;
  assign found_length    = res_entry.len;
  assign found_read_only = res_entry.ro;
  assign found_size      = res_entry.size;
  assign found_offset    = res_entry.offset;
  assign found_mip       = res_entry.mip;
  assign found_alloc     = res_entry.alloc;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_BITS'(ENTRIES))
    else $error("entry count beyond table depth");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a request in progress");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("busy not raised after a request transfer");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (issue_idx <= count))
    else $error("scan index ran past the entry count");
`endif

endmodule

`default_nettype wire

>>> rtl/core/mrt_table.sv
// Single write, single read entry store with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module mrt_table (
  input  logic                         clk,
  input  logic                         we,
  input  logic [mrt_pkg::IDX_BITS-1:0] wr_addr,
  input  mrt_pkg::entry_t              wr_data,
  input  logic [mrt_pkg::IDX_BITS-1:0] rd_addr,
  output mrt_pkg::entry_t              rd_data
);
  import mrt_pkg::*;

  entry_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> rtl/core/mrt_match.sv
// Shared compare unit: tests one stored entry against the current request.
`timescale 1ns / 1ps
`default_nettype none

module mrt_match (
  input  mrt_pkg::query_t query,
  input  mrt_pkg::entry_t entry,
  output logic            match
);
  import mrt_pkg::*;

  logic [END_BITS-1:0] q_start;
  logic [END_BITS-1:0] e_start;

  assign q_start = END_BITS'(query.addr);
  assign e_start = END_BITS'(entry.start);

  always_comb begin
    case (query.op)
      // A new range that ends where a stored one starts counts as overlap, hence the inclusive upper test.
      OP_ADD:          match = (q_start < entry.end_addr) && (query.end_addr >= e_start);
      OP_FIND_EXACT:   match = (entry.start == query.addr);
      OP_FIND_CONTAIN: match = (e_start <= q_start) && (entry.end_addr >= query.end_addr);
      OP_REMOVE:       match = (entry.start == query.addr);
      default:         match = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

>>> test/mrt_result_checker.sv
// Checker that predicts each mapped range table result and compares it with the block's output.
`timescale 1ns / 1ps

module mrt_result_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic                            busy,
  input  logic [1:0]                      opcode,
  input  logic [mrt_pkg::ADDR_BITS-1:0]   address,
  input  logic [mrt_pkg::LEN_BITS-1:0]    length,
  input  logic                            read_only,
  input  logic [mrt_pkg::SIZE_BITS-1:0]   size_packed,
  input  logic [mrt_pkg::OFFSET_BITS-1:0] offset_packed,
  input  logic [mrt_pkg::MIP_BITS-1:0]    mip_level,
  input  logic [mrt_pkg::ALLOC_BITS-1:0]  alloc_handle,
  input  logic                            done,
  input  logic [1:0]                      status,
  input  logic [mrt_pkg::CNT_BITS-1:0]    entry_count,
  input  logic [mrt_pkg::ADDR_BITS-1:0]   found_address,
  input  logic [mrt_pkg::LEN_BITS-1:0]    found_length,
  input  logic                            found_read_only,
  input  logic [mrt_pkg::SIZE_BITS-1:0]   found_size,
  input  logic [mrt_pkg::OFFSET_BITS-1:0] found_offset,
  input  logic [mrt_pkg::MIP_BITS-1:0]    found_mip,
  input  logic [mrt_pkg::ALLOC_BITS-1:0]  found_alloc,
  output int                              error_count,
  output int                              outstanding
);

  import mrt_pkg::*;

  typedef struct packed {
    status_t                status;
    logic [CNT_BITS-1:0]    count;
    logic [ADDR_BITS-1:0]   addr;
    logic [LEN_BITS-1:0]    len;
    logic                   ro;
    logic [SIZE_BITS-1:0]   size;
    logic [OFFSET_BITS-1:0] offset;
    logic [MIP_BITS-1:0]    mip;
    logic [ALLOC_BITS-1:0]  alloc;
  } table_result_t;

  entry_t        range_slot [ENTRIES];
  int            ranges_held;
  table_result_t results_due [$];

  initial begin
    error_count = 0;
    outstanding = 0;
    ranges_held = 0;
  end

  // Applies one request to the local copy of the table and returns what the block should report.
  function automatic table_result_t apply_request(opcode_t op, logic [ADDR_BITS-1:0] addr,
                                                  logic [LEN_BITS-1:0] len, logic ro,
                                                  logic [SIZE_BITS-1:0] pay_size,
                                                  logic [OFFSET_BITS-1:0] pay_offset,
                                                  logic [MIP_BITS-1:0] pay_mip,
                                                  logic [ALLOC_BITS-1:0] pay_alloc);
    table_result_t r;
    logic [END_BITS-1:0] q_end;
    bit hit;
    int idx;
    r = '0;
    hit = 1'b0;
    idx = 0;
    q_end = END_BITS'(addr) + END_BITS'(len);
    case (op)
      OP_ADD: begin
        // A new range ending where a stored one starts counts as overlap; read-only maps are never checked.
        for (int i = 0; i < ranges_held; i++) begin
          if (!ro && END_BITS'(addr) < range_slot[i].end_addr &&
              q_end >= END_BITS'(range_slot[i].start)) hit = 1'b1;
        end
        if (hit) begin
          r.status = STATUS_OVERLAP;
        end else if (ranges_held >= ENTRIES) begin
          r.status = STATUS_FULL;
        end else begin
          range_slot[ranges_held] = '{start: addr, end_addr: q_end, len: len, ro: ro,
                                      size: pay_size, offset: pay_offset, mip: pay_mip,
                                      alloc: pay_alloc};
          ranges_held++;
        end
      end
      default: begin
        // Scanning from the top down leaves the lowest matching slot in idx.
        for (int i = ranges_held - 1; i >= 0; i--) begin
          if (op == OP_FIND_CONTAIN ?
              (range_slot[i].start <= addr && range_slot[i].end_addr >= q_end) :
              (range_slot[i].start == addr)) begin
            hit = 1'b1;
            idx = i;
          end
        end
        if (!hit) begin
          r.status = STATUS_NOT_FOUND;
        end else if (op == OP_REMOVE) begin
          range_slot[idx] = range_slot[ranges_held - 1];
          ranges_held--;
        end else begin
          r.addr   = range_slot[idx].start;
          r.len    = range_slot[idx].len;
          r.ro     = range_slot[idx].ro;
          r.size   = range_slot[idx].size;
          r.offset = range_slot[idx].offset;
          r.mip    = range_slot[idx].mip;
          r.alloc  = range_slot[idx].alloc;
        end
      end
    endcase
    r.count = CNT_BITS'(ranges_held);
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    table_result_t want;
    if (rst) begin
      ranges_held = 0;
      results_due.delete();
    end else begin
      // A result transfer is checked before a request taken at the same edge is predicted.
      if (done) begin
        if (results_due.size() == 0) begin
          $error("result transfer with no request outstanding");
          error_count++;
        end else begin
          want = results_due.pop_front();
          check_field("status", 64'(want.status), 64'(status));
          check_field("entry_count", 64'(want.count), 64'(entry_count));
          check_field("found_address", 64'(want.addr), 64'(found_address));
          check_field("found_length", 64'(want.len), 64'(found_length));
          check_field("found_read_only", 64'(want.ro), 64'(found_read_only));
          check_field("found_size", 64'(want.size), 64'(found_size));
          check_field("found_offset", 64'(want.offset), 64'(found_offset));
          check_field("found_mip", 64'(want.mip), 64'(found_mip));
          check_field("found_alloc", 64'(want.alloc), 64'(found_alloc));
        end
      end
      if (start && !busy) begin
        results_due.insert(results_due.size(),
                           apply_request(opcode_t'(opcode), address, length, read_only,
                                         size_packed, offset_packed, mip_level,
                                         alloc_handle));
      end
    end
    outstanding = results_due.size();
  end

endmodule

>>> test/tb_mapped_range_table_core.sv
// Testbench top for the mapped range table: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module tb_mapped_range_table_core;

  import mrt_pkg::*;

  typedef struct {
    logic [ADDR_BITS-1:0] addr;
    logic [LEN_BITS-1:0]  len;
  } span_t;

  typedef enum int {
    TRAFFIC_FILL,
    TRAFFIC_DRAIN,
    TRAFFIC_MIXED
  } traffic_t;

  logic                   clk;
  logic                   rst;
  logic                   start;
  logic                   busy;
  logic [1:0]             opcode;
  logic [ADDR_BITS-1:0]   address;
  logic [LEN_BITS-1:0]    length;
  logic                   read_only;
  logic [SIZE_BITS-1:0]   size_packed;
  logic [OFFSET_BITS-1:0] offset_packed;
  logic [MIP_BITS-1:0]    mip_level;
  logic [ALLOC_BITS-1:0]  alloc_handle;
  logic                   done;
  logic [1:0]             status;
  logic [CNT_BITS-1:0]    entry_count;
  logic [ADDR_BITS-1:0]   found_address;
  logic [LEN_BITS-1:0]    found_length;
  logic                   found_read_only;
  logic [SIZE_BITS-1:0]   found_size;
  logic [OFFSET_BITS-1:0] found_offset;
  logic [MIP_BITS-1:0]    found_mip;
  logic [ALLOC_BITS-1:0]  found_alloc;

  int    fail_count;
  int    results_pending;
  bit    allow_idle;
  span_t span_pool [$];

  mapped_range_table_core u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode), .address(address),
    .length(length), .read_only(read_only), .size_packed(size_packed),
    .offset_packed(offset_packed), .mip_level(mip_level), .alloc_handle(alloc_handle),
    .done(done), .status(status), .entry_count(entry_count), .found_address(found_address),
    .found_length(found_length), .found_read_only(found_read_only), .found_size(found_size),
    .found_offset(found_offset), .found_mip(found_mip), .found_alloc(found_alloc)
  );

  mrt_result_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode), .address(address),
    .length(length), .read_only(read_only), .size_packed(size_packed),
    .offset_packed(offset_packed), .mip_level(mip_level), .alloc_handle(alloc_handle),
    .done(done), .status(status), .entry_count(entry_count), .found_address(found_address),
    .found_length(found_length), .found_read_only(found_read_only), .found_size(found_size),
    .found_offset(found_offset), .found_mip(found_mip), .found_alloc(found_alloc),
    .error_count(fail_count), .outstanding(results_pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [47:0] rand48();
    return 48'({$urandom, $urandom});
  endfunction

  // Drives one request from a falling edge and returns once the block has taken it.
  task automatic send_request(opcode_t op, logic [ADDR_BITS-1:0] addr, logic [LEN_BITS-1:0] len,
                              logic ro, logic [SIZE_BITS-1:0] pay_size,
                              logic [OFFSET_BITS-1:0] pay_offset, logic [MIP_BITS-1:0] pay_mip,
                              logic [ALLOC_BITS-1:0] pay_alloc);
    @(negedge clk);
    while (allow_idle && $urandom_range(99) < 24) begin
      start <= 1'b0;
      @(negedge clk);
    end
    opcode        <= op;
    address       <= addr;
    length        <= len;
    read_only     <= ro;
    size_packed   <= pay_size;
    offset_packed <= pay_offset;
    mip_level     <= pay_mip;
    alloc_handle  <= pay_alloc;
    start         <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic send_random_payload(opcode_t op, logic [ADDR_BITS-1:0] addr,
                                     logic [LEN_BITS-1:0] len, logic ro);
    send_request(op, addr, len, ro, rand48(), rand48(), MIP_BITS'($urandom),
                 ALLOC_BITS'($urandom));
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    start <= 1'b0;
    while (results_pending != 0) @(negedge clk);
  endtask

  // Builds one random request, leaning on earlier ranges so that hits, overlaps and misses all occur.
  task automatic send_random_request(traffic_t mode);
    span_t           pick;
    span_t           fresh;
    opcode_t         op;
    logic [47:0]     a;
    logic [31:0]     l;
    logic            ro;
    logic [63:0]     rem;
    logic [63:0]     off;
    int              sel;
    int              idx;
    bit              have;
    sel = $urandom_range(99);
    case (mode)
      TRAFFIC_FILL:  op = (sel < 85) ? OP_ADD : opcode_t'($urandom_range(3));
      TRAFFIC_DRAIN: op = (sel < 70) ? OP_REMOVE : opcode_t'($urandom_range(3));
      default:       op = opcode_t'($urandom_range(3));
    endcase
    sel = $urandom_range(99);
    if (sel < 30)      l = $urandom_range(64);
    else if (sel < 40) l = '0;
    else if (sel < 50) l = '1;
    else if (sel < 60) l = $urandom_range(4096, 256);
    else               l = $urandom;
    a = rand48();
    ro = logic'($urandom_range(1));
    have = span_pool.size() != 0;
    idx = 0;
    if (have) begin
      idx = $urandom_range(span_pool.size() - 1);
      pick = span_pool[idx];
    end
    sel = $urandom_range(99);
    case (op)
      OP_ADD: begin
        if (have && sel < 15)      a = pick.addr + 48'($urandom_range(64)) - 48'd32;
        else if (have && sel < 25) a = pick.addr + 48'(pick.len);
        else if (have && sel < 35) a = pick.addr - 48'(l);
        else if (sel < 50)         a = 48'($urandom_range(4095));
        else if (sel < 58)         a = ~48'($urandom_range(255));
        if (mode != TRAFFIC_FILL) ro = ($urandom_range(99) < 30);
        fresh.addr = a;
        fresh.len = l;
        span_pool.insert(span_pool.size(), fresh);
        if (span_pool.size() > 48) void'(span_pool.pop_front());
      end
      OP_FIND_CONTAIN: begin
        if (have && sel < 70) begin
          rem = 64'(pick.len);
          off = {$urandom, $urandom} % (rem + 64'd1);
          a = pick.addr + 48'(off);
          rem = rem - off;
          // A few queries reach one byte past the stored end.
          l = (sel < 10) ? 32'(rem + 64'd1) : 32'({$urandom, $urandom} % (rem + 64'd1));
        end
      end
      default: begin
        if (have && sel < 75) begin
          a = pick.addr;
          if (op == OP_REMOVE && $urandom_range(99) < 70) span_pool.delete(idx);
        end
      end
    endcase
    send_random_payload(op, a, l, ro);
  endtask

  initial begin
    int sent;
    int burst;
    int guard;
    traffic_t mode;
    rst = 1'b1;
    start = 1'b0;
    opcode = OP_ADD;
    address = '0;
    length = '0;
    read_only = 1'b0;
    size_packed = '0;
    offset_packed = '0;
    mip_level = '0;
    alloc_handle = '0;
    allow_idle = 1'b1;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // Searches and a remove on an empty table.
    send_random_payload(OP_FIND_EXACT, '0, '0, 1'b0);
    send_random_payload(OP_FIND_CONTAIN, '0, '0, 1'b0);
    send_random_payload(OP_REMOVE, '0, '0, 1'b0);
    send_request(OP_ADD, 48'h100, 32'h100, 1'b0, '1, '1, '1, '1);
    // Ends exactly where the stored range starts, which counts as overlap.
    send_random_payload(OP_ADD, 48'h80, 32'h80, 1'b0);
    // Starts exactly at the stored end, which does not.
    send_random_payload(OP_ADD, 48'h200, 32'h10, 1'b0);
    send_random_payload(OP_ADD, 48'h150, 32'h4, 1'b1);
    // The range end carries beyond the address width.
    send_request(OP_ADD, '1, '1, 1'b0, '0, '0, '0, '0);
    send_random_payload(OP_ADD, 48'hFFFF_FFFF_FFF0, '0, 1'b0);
    send_random_payload(OP_ADD, '1, '0, 1'b0);
    send_random_payload(OP_FIND_EXACT, 48'h150, '0, 1'b0);
    send_random_payload(OP_FIND_EXACT, 48'h151, '0, 1'b0);
    send_random_payload(OP_FIND_CONTAIN, 48'h100, 32'h100, 1'b0);
    send_random_payload(OP_FIND_CONTAIN, 48'h1FF, 32'h2, 1'b0);
    send_random_payload(OP_FIND_CONTAIN, '1, '1, 1'b1);
    // Removing the first slot moves the last entry into it.
    send_random_payload(OP_REMOVE, 48'h100, '0, 1'b0);
    send_random_payload(OP_FIND_EXACT, 48'hFFFF_FFFF_FFF0, '0, 1'b0);
    // Fill the table with read-only ranges, then add once more in each flavour.
    for (int k = 0; k < 12; k++) send_random_payload(OP_ADD, rand48(), $urandom, 1'b1);
    send_random_payload(OP_ADD, 48'h150, 32'h4, 1'b1);
    send_random_payload(OP_ADD, 48'h200, 32'h1, 1'b0);
    send_random_payload(OP_ADD, 48'h1000, 32'h1, 1'b0);
    send_random_payload(OP_REMOVE, 48'h200, '0, 1'b0);
    wait_for_results();

    sent = 0;
    while (sent < 1225) begin
      mode = traffic_t'($urandom_range(2));
      burst = $urandom_range(60, 20);
      for (int k = 0; k < burst && sent < 1225; k++) begin
        allow_idle = !(sent >= 400 && sent < 600);
        send_random_request(mode);
        sent++;
      end
      if ($urandom_range(99) < 20) wait_for_results();
    end

    @(negedge clk);
    start <= 1'b0;
    guard = 0;
    while (results_pending != 0 && guard < 2000) begin
      @(negedge clk);
      guard++;
    end
    repeat (40) @(negedge clk);
    if (fail_count == 0 && results_pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/mrt_pkg.sv
rtl/core/mrt_table.sv
rtl/core/mrt_match.sv
rtl/core/mapped_range_table_core.sv
test/mrt_result_checker.sv
test/tb_mapped_range_table_core.sv
